### hdl/mprast_pkg.sv
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer package
// Field widths, register indexes, operation codes and reset values shared by
// the rasterizer core.
// ----------------------------------------------------------------------------
package mprast_pkg;

    localparam int CENTER_W = 12;
    localparam int RADIUS_W = 11;
    localparam int DIM_W    = 13;
    localparam int PIX_W    = 14;
    localparam int ADDR_W   = 26;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

    typedef enum logic
    {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    typedef enum logic
    {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } operation_t;

endpackage

### hdl/midpoint_ellipse_rasterizer_core.sv
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer core
// Two-region midpoint ellipse walker that emits four symmetric pixels per
// step with bounds flag and RGBA byte address.
// ----------------------------------------------------------------------------
// Usage:
//   The item channel (item_valid / item_stall) takes commands. A start word
//   latches center and semi-axes and produces no result; the core is busy
//   while one shared multiplier forms a*a, b*b and 4*a*a*b*b.
//   A step word occupies the core with multiplies on that same unit
//   (slope test, squared terms, two row products for the addresses),
//   then hands out four pixel words through the output register, one per
//   cycle while the receiver does not stall.
//   A step on a finished or idle ellipse yields one finished word, after
//   the slope test (finished) or directly (idle).
//   The result channel (result_valid / result_stall) is held while the
//   receiver stalls; the core simply waits with the next word.
//   item_stall is high whenever a command is being worked on.
//   Reset clears the current ellipse (idle), sets the image to 640 x 480
//   and empties the output register.
//   Configuration writes (cfg_write) must be made while idle; the core does not enforce this.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_core #(
    parameter int COORD_BITS      = 12,
    parameter int BYTES_PER_PIXEL = 4
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_write,
    input  mprast_pkg::cfg_index_t                   cfg_index,
    input  logic [mprast_pkg::DIM_W-1:0]             cfg_data,
    input  logic                                     item_valid,
    output logic                                     item_stall,
    input  logic                                     operation,
    input  logic [mprast_pkg::CENTER_W-1:0]          center_x,
    input  logic [mprast_pkg::CENTER_W-1:0]          center_y,
    input  logic [mprast_pkg::RADIUS_W-1:0]          radius_x,
    input  logic [mprast_pkg::RADIUS_W-1:0]          radius_y,
    output logic                                     result_valid,
    input  logic                                     result_stall,
    output logic signed [mprast_pkg::PIX_W-1:0]      pixel_x,
    output logic signed [mprast_pkg::PIX_W-1:0]      pixel_y,
    output logic [mprast_pkg::ADDR_W-1:0]            byte_address,
    output logic                                     outside_image,
    output logic                                     finished,
    output logic                                     last_of_run
);

    import mprast_pkg::*;

    localparam int CW     = COORD_BITS;
    localparam int A2_W   = 2 * RADIUS_W;
    localparam int SQ_W   = 2 * CW + 3;
    localparam int MW     = (SQ_W > A2_W) ? SQ_W : A2_W;
    localparam int PRW    = 2 * MW;
    localparam int LHS_W  = A2_W + CW + 2;
    localparam int TERM_W = A2_W + SQ_W;
    localparam int AB_W   = 2 * A2_W + 2;
    localparam int DW     = ((TERM_W > AB_W) ? TERM_W : AB_W) + 2;
    localparam int SUM_W  = ((CW > CENTER_W) ? CW : CENTER_W) + 2;
    localparam int ROWP_W = 2 * DIM_W;

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_PRE_A2,
        S_PRE_B2,
        S_PRE_AB,
        S_PRE_DONE,
        S_LHS,
        S_RHS,
        S_SX,
        S_SY,
        S_BX,
        S_AY,
        S_ROW0,
        S_ROW1,
        S_EMIT,
        S_FINISH
    } state_t;

    state_t                  state_reg;
    logic [DIM_W-1:0]        width_reg;
    logic [DIM_W-1:0]        height_reg;
    logic                    drawing_reg;
    logic                    second_region_reg;
    logic signed [CW-1:0]    point_x_reg;
    logic [CW-1:0]           point_y_reg;
    logic [CENTER_W-1:0]     held_center_x_reg;
    logic [CENTER_W-1:0]     held_center_y_reg;
    logic [RADIUS_W-1:0]     held_radius_x_reg;
    logic [RADIUS_W-1:0]     held_radius_y_reg;
    logic [1:0]              emit_idx_reg;

    logic                    out_valid_reg;
    logic signed [PIX_W-1:0] out_pixel_x_reg;
    logic signed [PIX_W-1:0] out_pixel_y_reg;
    logic [ADDR_W-1:0]       out_address_reg;
    logic                    out_outside_reg;
    logic                    out_finished_reg;
    logic                    out_last_reg;

    logic [PRW-1:0]          prod_reg;
    logic [A2_W-1:0]         a2_reg;
    logic [A2_W-1:0]         b2_reg;
    logic [AB_W-1:0]         ab4_reg;
    logic [LHS_W-1:0]        lhs_reg;
    logic [2*CW-1:0]         sx_reg;
    logic [SQ_W-1:0]         sy_reg;
    logic [TERM_W-1:0]       bx_reg;
    logic signed [DW-1:0]    d_reg;
    logic [ROWP_W-1:0]       row0_reg;

    logic                    item_accept;
    logic                    out_load;
    logic [MW-1:0]           mul_a;
    logic [MW-1:0]           mul_b;
    logic [CW-1:0]           xu;
    logic [CW:0]             two_x_m1;
    logic [CW:0]             sx_op;
    logic [CW+1:0]           two_y_p2;
    logic [CW+1:0]           sy_op;
    logic                    region_now;
    logic signed [SUM_W-1:0] xs;
    logic signed [SUM_W-1:0] ys;
    logic signed [SUM_W-1:0] cxs;
    logic signed [SUM_W-1:0] cys;
    logic signed [SUM_W-1:0] px_plus;
    logic signed [SUM_W-1:0] px_minus;
    logic signed [SUM_W-1:0] py_plus;
    logic signed [SUM_W-1:0] py_minus;
    logic signed [SUM_W-1:0] emit_px;
    logic signed [SUM_W-1:0] emit_py;
    logic [ROWP_W-1:0]       emit_rowp;
    logic                    emit_outside;
    logic [ROWP_W:0]         addr_sum;
    logic [ADDR_W-1:0]       emit_addr;

    assign item_stall  = (state_reg != S_IDLE);
    assign item_accept = item_valid && !item_stall;
    assign out_load    = !out_valid_reg || !result_stall;

    assign xu       = $unsigned(point_x_reg);
    assign two_x_m1 = {xu, 1'b0} - (CW+1)'(1);
    assign two_y_p2 = (CW+2)'({point_y_reg, 1'b0}) + (CW+2)'(2);
    assign sy_op    = second_region_reg ? {1'b0, point_y_reg, 1'b1} : two_y_p2;

    assign region_now = second_region_reg ||
                        !(!point_x_reg[CW-1] && (xu != '0) && (lhs_reg > prod_reg[LHS_W-1:0]));

    always_comb
    begin
        if (region_now)
        begin
            sx_op = (xu == '0) ? (CW+1)'(2) : ({xu, 1'b0} - (CW+1)'(2));
        end
        else
        begin
            sx_op = two_x_m1;
        end
    end

    assign xs       = SUM_W'(point_x_reg);
    assign ys       = $signed({{(SUM_W-CW){1'b0}}, point_y_reg});
    assign cxs      = $signed({{(SUM_W-CENTER_W){1'b0}}, held_center_x_reg});
    assign cys      = $signed({{(SUM_W-CENTER_W){1'b0}}, held_center_y_reg});
    assign px_plus  = cxs + xs;
    assign px_minus = cxs - xs;
    assign py_plus  = cys + ys;
    assign py_minus = cys - ys;

    always_comb
    begin
        emit_px   = (emit_idx_reg == 2'd0 || emit_idx_reg == 2'd1) ? px_plus : px_minus;
        emit_py   = (emit_idx_reg == 2'd0 || emit_idx_reg == 2'd3) ? py_plus : py_minus;
        emit_rowp = (emit_idx_reg == 2'd0 || emit_idx_reg == 2'd3) ? row0_reg
                                                                   : prod_reg[ROWP_W-1:0];
        emit_outside = emit_px[SUM_W-1] || emit_py[SUM_W-1] ||
                       (emit_px >= $signed({{(SUM_W-DIM_W){1'b0}}, width_reg})) ||
                       (emit_py >= $signed({{(SUM_W-DIM_W){1'b0}}, height_reg}));
        addr_sum  = {1'b0, emit_rowp} + (ROWP_W+1)'(emit_px[DIM_W-1:0]);
        emit_addr = emit_outside ? '0
                                 : ADDR_W'(addr_sum * (ROWP_W+1)'(BYTES_PER_PIXEL));
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_PRE_A2:
            begin
                mul_a = MW'(held_radius_x_reg);
                mul_b = MW'(held_radius_x_reg);
            end
            S_PRE_B2:
            begin
                mul_a = MW'(held_radius_y_reg);
                mul_b = MW'(held_radius_y_reg);
            end
            S_PRE_AB:
            begin
                mul_a = MW'(a2_reg);
                mul_b = MW'(prod_reg[A2_W-1:0]);
            end
            S_LHS:
            begin
                mul_a = MW'(b2_reg);
                mul_b = MW'(two_x_m1);
            end
            S_RHS:
            begin
                mul_a = MW'(a2_reg);
                mul_b = MW'(two_y_p2);
            end
            S_SX:
            begin
                mul_a = MW'(sx_op);
                mul_b = MW'(sx_op);
            end
            S_SY:
            begin
                mul_a = MW'(sy_op);
                mul_b = MW'(sy_op);
            end
            S_BX:
            begin
                mul_a = MW'(b2_reg);
                mul_b = MW'(sx_reg);
            end
            S_AY:
            begin
                mul_a = MW'(a2_reg);
                mul_b = MW'(sy_reg);
            end
            S_ROW0:
            begin
                mul_a = MW'(py_plus[DIM_W-1:0]);
                mul_b = MW'(width_reg);
            end
            S_ROW1, S_EMIT:
            begin
                mul_a = MW'(py_minus[DIM_W-1:0]);
                mul_b = MW'(width_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        unique case (state_reg)
            S_PRE_B2:   a2_reg   <= prod_reg[A2_W-1:0];
            S_PRE_AB:   b2_reg   <= prod_reg[A2_W-1:0];
            S_PRE_DONE: ab4_reg  <= {prod_reg[2*A2_W-1:0], 2'b00};
            S_RHS:      lhs_reg  <= prod_reg[LHS_W-1:0];
            S_SY:       sx_reg   <= prod_reg[2*CW-1:0];
            S_BX:       sy_reg   <= prod_reg[SQ_W-1:0];
            S_AY:       bx_reg   <= prod_reg[TERM_W-1:0];
            S_ROW0:     d_reg    <= $signed(DW'(bx_reg)) + $signed(DW'(prod_reg[TERM_W-1:0]))
                                    - $signed(DW'(ab4_reg));
            S_ROW1:     row0_reg <= prod_reg[ROWP_W-1:0];
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            width_reg         <= WIDTH_RESET;
            height_reg        <= HEIGHT_RESET;
            drawing_reg       <= 1'b0;
            second_region_reg <= 1'b0;
            point_x_reg       <= '0;
            point_y_reg       <= '0;
            held_center_x_reg <= '0;
            held_center_y_reg <= '0;
            held_radius_x_reg <= '0;
            held_radius_y_reg <= '0;
            emit_idx_reg      <= '0;
            out_valid_reg     <= 1'b0;
            out_pixel_x_reg   <= '0;
            out_pixel_y_reg   <= '0;
            out_address_reg   <= '0;
            out_outside_reg   <= 1'b0;
            out_finished_reg  <= 1'b0;
            out_last_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                    CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                endcase
            end

            if (out_load)
            begin
                out_valid_reg <= (state_reg == S_EMIT) || (state_reg == S_FINISH);
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (item_accept)
                    begin
                        if (operation == OP_START)
                        begin
                            held_center_x_reg <= center_x;
                            held_center_y_reg <= center_y;
                            held_radius_x_reg <= radius_x;
                            held_radius_y_reg <= radius_y;
                            point_x_reg       <= CW'(radius_x);
                            point_y_reg       <= '0;
                            second_region_reg <= 1'b0;
                            drawing_reg       <= 1'b1;
                            state_reg         <= S_PRE_A2;
                        end
                        else if (drawing_reg)
                        begin
                            state_reg <= S_LHS;
                        end
                        else
                        begin
                            state_reg <= S_FINISH;
                        end
                    end
                end
                S_PRE_A2:   state_reg <= S_PRE_B2;
                S_PRE_B2:   state_reg <= S_PRE_AB;
                S_PRE_AB:   state_reg <= S_PRE_DONE;
                S_PRE_DONE: state_reg <= S_IDLE;
                S_LHS:      state_reg <= S_RHS;
                S_RHS:      state_reg <= S_SX;
                S_SX:
                begin
                    second_region_reg <= region_now;
                    if (region_now && point_x_reg[CW-1])
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_SY;
                    end
                end
                S_SY:       state_reg <= S_BX;
                S_BX:       state_reg <= S_AY;
                S_AY:       state_reg <= S_ROW0;
                S_ROW0:     state_reg <= S_ROW1;
                S_ROW1:
                begin
                    emit_idx_reg <= '0;
                    state_reg    <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_load)
                    begin
                        out_pixel_x_reg  <= emit_px[PIX_W-1:0];
                        out_pixel_y_reg  <= emit_py[PIX_W-1:0];
                        out_address_reg  <= emit_addr;
                        out_outside_reg  <= emit_outside;
                        out_finished_reg <= 1'b0;
                        out_last_reg     <= (emit_idx_reg == 2'd3);
                        if (emit_idx_reg == 2'd3)
                        begin
                            if (!second_region_reg)
                            begin
                                if (!d_reg[DW-1])
                                begin
                                    point_x_reg <= point_x_reg - CW'(1);
                                end
                                point_y_reg <= point_y_reg + CW'(1);
                            end
                            else
                            begin
                                if (d_reg[DW-1])
                                begin
                                    point_y_reg <= point_y_reg + CW'(1);
                                end
                                point_x_reg <= point_x_reg - CW'(1);
                            end
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            emit_idx_reg <= emit_idx_reg + 2'd1;
                        end
                    end
                end
                S_FINISH:
                begin
                    if (out_load)
                    begin
                        out_pixel_x_reg  <= '0;
                        out_pixel_y_reg  <= '0;
                        out_address_reg  <= '0;
                        out_outside_reg  <= 1'b0;
                        out_finished_reg <= 1'b1;
                        out_last_reg     <= 1'b1;
                        drawing_reg      <= 1'b0;
                        state_reg        <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign result_valid  = out_valid_reg;
    assign pixel_x       = out_pixel_x_reg;
    assign pixel_y       = out_pixel_y_reg;
    assign byte_address  = out_address_reg;
    assign outside_image = out_outside_reg;
    assign finished      = out_finished_reg;
    assign last_of_run   = out_last_reg;

    // advance through the four symmetric pixels one word at a time
    a_emit_advance: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT && out_load && emit_idx_reg != 2'd3
        |=> state_reg == S_EMIT && emit_idx_reg == $past(emit_idx_reg) + 2'd1
            && result_valid && !last_of_run)
        else $error("pixel sequence skipped or stalled a word");

    // close a step with a valid last word and return to idle
    a_emit_close: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT && out_load && emit_idx_reg == 2'd3
        |=> state_reg == S_IDLE && result_valid && last_of_run && !finished)
        else $error("step did not close with its last pixel");

    // hold address at zero for finished and out-of-image words
    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (finished || outside_image) |-> byte_address == '0)
        else $error("address set on finished or outside word");

endmodule
